/* rtl/core/gaps_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the grid path search block.
// No dependencies; used by gaps_ctrl, gaps_dp and grid_astar_path_search.
package gaps_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR_ALL,
    OP_LOAD,
    OP_WRITE_PROP,
    OP_RD_CELL,
    OP_SRCH_INIT,
    OP_CLR_VIS,
    OP_START_RD,
    OP_START,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_POP,
    OP_SHIFT,
    OP_POP_DONE,
    OP_NB_RD,
    OP_NB_EVAL,
    OP_NB_PUSH,
    OP_RD_GOAL,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       clr_last;
    logic       open_empty;
    logic       scan_busy;
    logic       shift_busy;
    logic       nb_last;
    logic       out_busy;
  } dp_stat_t;

  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_W      = 12;
  localparam int TOT_W      = 24;
  localparam int STEP_W     = 13;

  localparam logic [STEP_W-1:0] STEP_STRAIGHT = 13'd256;
  localparam logic [STEP_W-1:0] STEP_DIAG     = 13'd362;
  localparam logic [7:0]        HEUR_MINOR    = 8'd106;
  localparam logic [7:0]        PROP_FREE     = 8'h00;
  localparam logic [7:0]        PROP_WALL     = 8'h01;
  localparam logic [7:0]        PROP_SOLID    = 8'hFF;
  localparam logic [CFG_W-1:0]  WALL_MULT_RST = 12'd256;

  // neighbor order: four straight steps, then four diagonals
  localparam logic signed [1:0] NB_DX [0:7] =
    '{2'sd0, 2'sd0, -2'sd1, 2'sd1, -2'sd1, 2'sd1, 2'sd1, -2'sd1};
  localparam logic signed [1:0] NB_DY [0:7] =
    '{-2'sd1, 2'sd1, 2'sd0, 2'sd0, -2'sd1, 2'sd1, -2'sd1, 2'sd1};

endpackage

/* rtl/core/gaps_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gaps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/gaps_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the grid path search: walks commands, clear sweeps,
// open list scan/compaction and neighbor expansion. Depends on gaps_pkg.
module gaps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  gaps_pkg::dp_stat_t stat,
  output gaps_pkg::dp_cmd_t  cmd
);
  import gaps_pkg::*;

  typedef enum logic [3:0] {
    S_RST, S_IDLE, S_DISPATCH, S_CLR, S_START_RD, S_START, S_POP_CHK,
    S_SCAN, S_SHIFT, S_NB_RD, S_NB_EVAL, S_NB_PUSH, S_RESULT
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_RST: begin
        cmd.op = OP_CLR_ALL;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_RESULT;
        unique case (stat.cmd)
          CMD_WRITE:  cmd.op = OP_WRITE_PROP;
          CMD_READ:   cmd.op = OP_RD_CELL;
          CMD_SEARCH: begin
            cmd.op    = OP_SRCH_INIT;
            state_nxt = S_CLR;
          end
          default:    cmd.op = OP_NONE;
        endcase
      end
      S_CLR: begin
        cmd.op = OP_CLR_VIS;
        if (stat.clr_last) state_nxt = S_START_RD;
      end
      S_START_RD: begin
        cmd.op    = OP_START_RD;
        state_nxt = S_START;
      end
      S_START: begin
        cmd.op    = OP_START;
        state_nxt = S_POP_CHK;
      end
      S_POP_CHK: begin
        if (stat.open_empty) begin
          cmd.op    = OP_RD_GOAL;
          state_nxt = S_RESULT;
        end else begin
          cmd.op    = OP_SCAN_INIT;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_busy) begin
          cmd.op = OP_SCAN;
        end else begin
          cmd.op    = OP_POP;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (stat.shift_busy) begin
          cmd.op = OP_SHIFT;
        end else begin
          cmd.op    = OP_POP_DONE;
          state_nxt = S_NB_RD;
        end
      end
      S_NB_RD: begin
        cmd.op    = OP_NB_RD;
        state_nxt = S_NB_EVAL;
      end
      S_NB_EVAL: begin
        cmd.op    = OP_NB_EVAL;
        state_nxt = S_NB_PUSH;
      end
      S_NB_PUSH: begin
        cmd.op    = OP_NB_PUSH;
        state_nxt = stat.nb_last ? S_POP_CHK : S_NB_RD;
      end
      S_RESULT: begin
        // hold until the previous word has left the output register
        if (!stat.out_busy) begin
          cmd.op    = OP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_RST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RST;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/gaps_dp.sv */
`timescale 1ns / 1ps
// Datapath of the grid path search: map, marks, costs, open list,
// step/heuristic arithmetic and the result register. Depends on gaps_pkg, gaps_ram.
module gaps_dp #(
  parameter int GRID_W     = 64,
  parameter int GRID_H     = 64,
  parameter int OPEN_DEPTH = 1024,
  parameter int COST_BITS  = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gaps_pkg::dp_cmd_t              cmd,
  output gaps_pkg::dp_stat_t             stat,
  input  logic [gaps_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [gaps_pkg::IN_USER_W-1:0] in_tuser,
  input  logic                           cfg_wr_en,
  input  logic [gaps_pkg::CFG_W-1:0]     cfg_wr_data,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [gaps_pkg::OUT_DATA_W-1:0] out_tdata
);
  import gaps_pkg::*;

  localparam int CELLS = GRID_W * GRID_H;
  localparam int AW    = $clog2(CELLS);
  localparam int CXW   = $clog2(GRID_W);
  localparam int CYW   = $clog2(GRID_H);
  localparam int HAW   = $clog2(OPEN_DEPTH);
  localparam int OCW   = $clog2(OPEN_DEPTH + 1);
  localparam int CLW   = $clog2(CELLS + 1);
  localparam int CNW   = (CLW > OCW) ? CLW : OCW;
  localparam int HXW   = (CXW > 6) ? CXW : 6;
  localparam int HYW   = (CYW > 6) ? CYW : 6;
  localparam int HDW   = (HXW > HYW) ? HXW : HYW;
  localparam int HW    = HDW + 9;
  localparam int SW0   = (COST_BITS > HW) ? COST_BITS : HW;
  localparam int SUMW  = ((SW0 > TOT_W) ? SW0 : TOT_W) + 1;
  localparam int CLXW  = CYW + CXW;
  localparam int HEW   = CLXW + TOT_W;
  localparam int CRW   = COST_BITS + 4;

  // latched command word
  logic [1:0]  cmd_r;
  logic [5:0]  x_r, y_r, sx_r, sy_r, ex_r, ey_r;
  logic [7:0]  val_r;
  logic        weap_r;
  logic [23:0] maxd_r;

  logic [CFG_W-1:0]  wall_mult_r;
  logic [STEP_W-1:0] wall_s_r, wall_d_r;
  logic [CNW-1:0]    cnt_r;
  logic [OCW-1:0]    open_cnt_r;
  logic              ovf_r;

  logic              sc_v_r, sh_v_r, have_r;
  logic [HAW-1:0]    sc_i_r, sh_w_r, best_i_r;
  logic [TOT_W-1:0]  best_tot_r;
  logic [CLXW-1:0]   best_cell_r;

  logic [CXW-1:0]       cur_x_r, nb_x_r;
  logic [CYW-1:0]       cur_y_r, nb_y_r;
  logic [COST_BITS-1:0] cur_cost_r, new_cost_r;
  logic [2:0]           nb_k_r;
  logic                 nb_in_r, upd_r;
  logic [AW-1:0]        nb_addr_r;
  logic [HW-1:0]        heur_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // RAM ports
  logic              pr_we, pr_re, vs_we, vs_re, cs_we, cs_re, hp_we, hp_re;
  logic [AW-1:0]     pr_wa, pr_ra, vs_wa, vs_ra, cs_wa, cs_ra;
  logic [7:0]        pr_wd, pr_rd;
  logic              vs_wd, vs_rd;
  logic [CRW-1:0]    cs_wd, cs_rd;
  logic [HAW-1:0]    hp_wa, hp_ra;
  logic [HEW-1:0]    hp_wd, hp_rd;

  function automatic logic [AW-1:0] cell_addr(input logic [CXW-1:0] cx,
                                             input logic [CYW-1:0] cy);
    return AW'(cy) * AW'(GRID_W) + AW'(cx);
  endfunction

  function automatic logic passable(input logic [7:0] prop, input logic weap);
    return weap ? (prop != PROP_SOLID) : (prop == PROP_FREE);
  endfunction

  logic x_ok, sx_ok, ex_ok;
  assign x_ok  = (int'(x_r) < GRID_W) && (int'(y_r) < GRID_H);
  assign sx_ok = (int'(sx_r) < GRID_W) && (int'(sy_r) < GRID_H);
  assign ex_ok = (int'(ex_r) < GRID_W) && (int'(ey_r) < GRID_H);

  logic [AW-1:0] xy_addr, start_addr, end_addr;
  assign xy_addr    = cell_addr(CXW'(x_r), CYW'(y_r));
  assign start_addr = cell_addr(CXW'(sx_r), CYW'(sy_r));
  assign end_addr   = cell_addr(CXW'(ex_r), CYW'(ey_r));

  // octile heuristic, shared by start push and neighbor evaluation
  logic [CXW-1:0] hx;
  logic [CYW-1:0] hy;
  logic [HDW-1:0] hxe, hye, exe, eye, ddx, ddy, dmax, dmin;
  logic [HW-1:0]  heur_w;
  always_comb begin
    hx     = (cmd.op == OP_START) ? CXW'(sx_r) : nb_x_r;
    hy     = (cmd.op == OP_START) ? CYW'(sy_r) : nb_y_r;
    hxe    = HDW'(hx);
    hye    = HDW'(hy);
    exe    = HDW'(ex_r);
    eye    = HDW'(ey_r);
    ddx    = (hxe >= exe) ? hxe - exe : exe - hxe;
    ddy    = (hye >= eye) ? hye - eye : eye - hye;
    dmax   = (ddx > ddy) ? ddx : ddy;
    dmin   = (ddx > ddy) ? ddy : ddx;
    heur_w = (HW'(dmax) << 8) + HW'(dmin) * HW'(HEUR_MINOR);
  end

  // neighbor coordinates
  logic signed [1:0] nb_dx, nb_dy;
  logic [CXW-1:0]    nx_w;
  logic [CYW-1:0]    ny_w;
  logic              nx_ok, ny_ok;
  always_comb begin
    nb_dx = NB_DX[nb_k_r];
    nb_dy = NB_DY[nb_k_r];
    nx_w  = cur_x_r + CXW'(nb_dx);
    ny_w  = cur_y_r + CYW'(nb_dy);
    nx_ok = (nb_dx == 2'sd0) ||
            ((nb_dx == 2'sd1) ? (int'(cur_x_r) != GRID_W - 1) : (cur_x_r != '0));
    ny_ok = (nb_dy == 2'sd0) ||
            ((nb_dy == 2'sd1) ? (int'(cur_y_r) != GRID_H - 1) : (cur_y_r != '0));
  end

  // relaxation of one neighbor
  logic [STEP_W-1:0]    step_w;
  logic [COST_BITS:0]   cost_sum;
  logic [COST_BITS-1:0] new_cost;
  logic                 nb_pass, upd_w;
  always_comb begin
    nb_pass = nb_in_r && passable(pr_rd, weap_r);
    if (pr_rd == PROP_WALL) begin
      step_w = (nb_k_r < 3'd4) ? wall_s_r : wall_d_r;
    end else begin
      step_w = (nb_k_r < 3'd4) ? STEP_STRAIGHT : STEP_DIAG;
    end
    cost_sum = (COST_BITS+1)'(cur_cost_r) + (COST_BITS+1)'(step_w);
    new_cost = cost_sum[COST_BITS] ? '1 : cost_sum[COST_BITS-1:0];
    upd_w    = nb_pass && (!vs_rd || (new_cost < cs_rd[COST_BITS-1:0]));
  end

  logic [SUMW-1:0] tot_w;
  logic            push_w, full_w;
  assign tot_w  = SUMW'(new_cost_r) + SUMW'(heur_r);
  assign push_w = upd_r && (tot_w < SUMW'(maxd_r));
  assign full_w = (open_cnt_r == OCW'(OPEN_DEPTH));

  logic             start_ok;
  assign start_ok = sx_ok && passable(pr_rd, weap_r);

  logic [TOT_W-1:0] hp_tot;
  logic [CLXW-1:0]  hp_cell;
  logic             take_w, sc_more, sh_more;
  assign hp_tot  = hp_rd[TOT_W-1:0];
  assign hp_cell = hp_rd[HEW-1:TOT_W];
  assign take_w  = !have_r || (hp_tot < best_tot_r);
  assign sc_more = cnt_r < CNW'(open_cnt_r);
  assign sh_more = sc_more;

  // RAM port steering
  always_comb begin
    pr_we = 1'b0; pr_wa = cnt_r[AW-1:0]; pr_wd = PROP_FREE;
    pr_re = 1'b0; pr_ra = start_addr;
    vs_we = 1'b0; vs_wa = cnt_r[AW-1:0]; vs_wd = 1'b0;
    vs_re = 1'b0; vs_ra = xy_addr;
    cs_we = 1'b0; cs_wa = start_addr;    cs_wd = '0;
    cs_re = 1'b0; cs_ra = xy_addr;
    hp_we = 1'b0; hp_wa = '0;            hp_wd = {CYW'(sy_r), CXW'(sx_r), TOT_W'(heur_w)};
    hp_re = 1'b0; hp_ra = cnt_r[HAW-1:0];
    unique case (cmd.op)
      OP_CLR_ALL: begin
        pr_we = 1'b1;
        vs_we = 1'b1;
      end
      OP_CLR_VIS: vs_we = 1'b1;
      OP_WRITE_PROP: begin
        pr_we = x_ok;
        pr_wa = xy_addr;
        pr_wd = val_r;
      end
      OP_RD_CELL: begin
        vs_re = 1'b1;
        cs_re = 1'b1;
      end
      OP_RD_GOAL: begin
        vs_re = 1'b1; vs_ra = end_addr;
        cs_re = 1'b1; cs_ra = end_addr;
      end
      OP_START_RD: pr_re = 1'b1;
      OP_START: begin
        vs_we = start_ok; vs_wa = start_addr; vs_wd = 1'b1;
        cs_we = start_ok;
        hp_we = start_ok;
      end
      OP_SCAN: hp_re = sc_more;
      OP_POP: begin
        cs_re = 1'b1;
        cs_ra = cell_addr(best_cell_r[CXW-1:0], best_cell_r[CLXW-1:CXW]);
      end
      OP_SHIFT: begin
        hp_re = sh_more;
        hp_we = sh_v_r; hp_wa = sh_w_r; hp_wd = hp_rd;
      end
      OP_NB_RD: begin
        pr_re = 1'b1; pr_ra = cell_addr(nx_w, ny_w);
        vs_re = 1'b1; vs_ra = cell_addr(nx_w, ny_w);
        cs_re = 1'b1; cs_ra = cell_addr(nx_w, ny_w);
      end
      OP_NB_EVAL: begin
        vs_we = upd_w; vs_wa = nb_addr_r; vs_wd = 1'b1;
        cs_we = upd_w; cs_wa = nb_addr_r;
        cs_wd = {NB_DY[nb_k_r], NB_DX[nb_k_r], new_cost};
      end
      OP_NB_PUSH: begin
        hp_we = push_w && !full_w;
        hp_wa = open_cnt_r[HAW-1:0];
        hp_wd = {nb_y_r, nb_x_r, tot_w[TOT_W-1:0]};
      end
      default: ;
    endcase
  end

  gaps_ram #(.WIDTH(8), .DEPTH(CELLS)) u_props (
    .clk(clk), .we(pr_we), .waddr(pr_wa), .wdata(pr_wd),
    .re(pr_re), .raddr(pr_ra), .rdata(pr_rd)
  );
  gaps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_marks (
    .clk(clk), .we(vs_we), .waddr(vs_wa), .wdata(vs_wd),
    .re(vs_re), .raddr(vs_ra), .rdata(vs_rd)
  );
  gaps_ram #(.WIDTH(CRW), .DEPTH(CELLS)) u_costs (
    .clk(clk), .we(cs_we), .waddr(cs_wa), .wdata(cs_wd),
    .re(cs_re), .raddr(cs_ra), .rdata(cs_rd)
  );
  gaps_ram #(.WIDTH(HEW), .DEPTH(OPEN_DEPTH)) u_open (
    .clk(clk), .we(hp_we), .waddr(hp_wa), .wdata(hp_wd),
    .re(hp_re), .raddr(hp_ra), .rdata(hp_rd)
  );

  // result word
  logic        res_found, res_vis;
  logic [23:0] res_dist, res_cost;
  logic [1:0]  res_dx, res_dy;
  always_comb begin
    res_found = (cmd_r == CMD_SEARCH) && ex_ok && vs_rd;
    res_vis   = (cmd_r == CMD_READ) && x_ok && vs_rd;
    res_dist  = res_found ? 24'(cs_rd[COST_BITS-1:0]) : 24'd0;
    res_cost  = res_vis ? 24'(cs_rd[COST_BITS-1:0]) : 24'd0;
    res_dx    = res_vis ? cs_rd[COST_BITS+1:COST_BITS] : 2'd0;
    res_dy    = res_vis ? cs_rd[COST_BITS+3:COST_BITS+2] : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      wall_mult_r <= WALL_MULT_RST;
      cnt_r       <= '0;
      open_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      sc_v_r      <= 1'b0;
      sh_v_r      <= 1'b0;
      have_r      <= 1'b0;
      nb_k_r      <= '0;
    end else begin
      if (cfg_wr_en) wall_mult_r <= cfg_wr_data;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (cmd.op)
        OP_CLR_ALL, OP_CLR_VIS: cnt_r <= cnt_r + 1'b1;
        OP_LOAD: begin
          cmd_r  <= in_tuser;
          x_r    <= in_tdata[5:0];
          y_r    <= in_tdata[11:6];
          val_r  <= in_tdata[19:12];
          sx_r   <= in_tdata[25:20];
          sy_r   <= in_tdata[31:26];
          ex_r   <= in_tdata[37:32];
          ey_r   <= in_tdata[43:38];
          weap_r <= in_tdata[44];
          maxd_r <= in_tdata[68:45];
        end
        OP_SRCH_INIT: begin
          ovf_r      <= 1'b0;
          open_cnt_r <= '0;
          cnt_r      <= '0;
          // scaled wall steps, rounded half up
          wall_s_r <= STEP_W'((21'(STEP_STRAIGHT) * 21'(wall_mult_r) + 21'd128) >> 8);
          wall_d_r <= STEP_W'((21'(STEP_DIAG) * 21'(wall_mult_r) + 21'd128) >> 8);
        end
        OP_START: if (start_ok) open_cnt_r <= OCW'(1);
        OP_SCAN_INIT: begin
          cnt_r  <= '0;
          have_r <= 1'b0;
          sc_v_r <= 1'b0;
        end
        OP_SCAN: begin
          // strict compare keeps the earliest entry among equal totals
          if (sc_v_r && take_w) begin
            best_tot_r  <= hp_tot;
            best_i_r    <= sc_i_r;
            best_cell_r <= hp_cell;
            have_r      <= 1'b1;
          end
          sc_v_r <= sc_more;
          sc_i_r <= cnt_r[HAW-1:0];
          if (sc_more) cnt_r <= cnt_r + 1'b1;
        end
        OP_POP: begin
          cur_x_r <= best_cell_r[CXW-1:0];
          cur_y_r <= best_cell_r[CLXW-1:CXW];
          cnt_r   <= CNW'(best_i_r) + 1'b1;
          sh_v_r  <= 1'b0;
        end
        OP_SHIFT: begin
          // compact the list so that order stays insertion order
          sh_v_r <= sh_more;
          sh_w_r <= cnt_r[HAW-1:0] - 1'b1;
          if (sh_more) cnt_r <= cnt_r + 1'b1;
        end
        OP_POP_DONE: begin
          open_cnt_r <= open_cnt_r - 1'b1;
          cur_cost_r <= cs_rd[COST_BITS-1:0];
          nb_k_r     <= '0;
        end
        OP_NB_RD: begin
          nb_x_r    <= nx_w;
          nb_y_r    <= ny_w;
          nb_in_r   <= nx_ok && ny_ok;
          nb_addr_r <= cell_addr(nx_w, ny_w);
        end
        OP_NB_EVAL: begin
          new_cost_r <= new_cost;
          upd_r      <= upd_w;
          heur_r     <= heur_w;
        end
        OP_NB_PUSH: begin
          if (push_w) begin
            if (full_w) ovf_r <= 1'b1;
            else        open_cnt_r <= open_cnt_r + 1'b1;
          end
          nb_k_r <= nb_k_r + 1'b1;
        end
        OP_RESULT: begin
          out_valid_r <= 1'b1;
          out_data_r  <= {1'b0, ovf_r, res_dy, res_dx, res_cost, res_vis,
                          res_dist, res_found};
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    stat.cmd        = cmd_r;
    stat.clr_last   = (cnt_r == CNW'(CELLS - 1));
    stat.open_empty = (open_cnt_r == '0);
    stat.scan_busy  = sc_more || sc_v_r;
    stat.shift_busy = sh_more || sh_v_r;
    stat.nb_last    = (nb_k_r == 3'd7);
    stat.out_busy   = out_valid_r;
  end

  a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
    open_cnt_r <= OCW'(OPEN_DEPTH))
    else $error("open list count beyond depth");
  a_pop_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_POP) |-> have_r)
    else $error("pop without a scanned entry");
  a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.op == OP_RESULT))
    else $error("result word without result op");
  a_ovf_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> ($past(cmd.op == OP_NB_PUSH) && $past(full_w)))
    else $error("overflow flag set outside a full push");

endmodule

/* rtl/core/grid_astar_path_search.sv */
`timescale 1ns / 1ps
// Top level of the eight-neighbor grid path search.
// Depends on gaps_pkg, gaps_ctrl, gaps_dp (and gaps_ram through gaps_dp).
//
// One word in, one word out. After reset the block sweeps the cell map and
// visit marks to zero, one cell per clock, before it takes the first word;
// the config register can be written during that time. A cell write or cell
// read loads the word, performs the access and then writes the result word.
// A search first clears the visit marks, then runs one expansion per popped
// open-list entry: a linear scan of the open list plus a compaction of the
// entries behind the popped one (both passes go through the single read port
// of the open-list RAM), then a read, an evaluation and a push step for each
// of the eight neighbors. A new word may be taken while the previous result
// still waits in the output register; the new result then waits until that
// register is free.
module grid_astar_path_search #(
  parameter int GRID_W     = 64,
  parameter int GRID_H     = 64,
  parameter int OPEN_DEPTH = 1024,
  parameter int COST_BITS  = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // cell_x, cell_y, cell_value, start_x, start_y, end_x, end_y,
  // has_weapon, search depth bound, zero pad
  input  logic [gaps_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic [gaps_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // found, distance, visited, cell_cost, step_dx, step_dy,
  // open_overflow, zero pad
  output logic [gaps_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [gaps_pkg::CFG_W-1:0]      cfg_wr_data
);
  import gaps_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  gaps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  gaps_dp #(
    .GRID_W     (GRID_W),
    .GRID_H     (GRID_H),
    .OPEN_DEPTH (OPEN_DEPTH),
    .COST_BITS  (COST_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (dp_cmd),
    .stat        (dp_stat),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

/* verif/grid_astar_path_search_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for grid_astar_path_search: directed map/search/read words,
// then random words under three idle patterns. Depends on gaps_pkg and the RTL.
module grid_astar_path_search_test;
  import gaps_pkg::*;

  localparam int          GW          = 64;
  localparam int          NCELL       = 4096;
  localparam int          HEAP_MAX    = 1024;
  localparam int unsigned COST_SAT    = 24'hFFFFFF;
  localparam logic [1:0]  CMD_UNKNOWN = 2'd3;

  typedef struct packed {
    logic        ovf;
    logic [1:0]  dy;
    logic [1:0]  dx;
    logic [23:0] cost;
    logic        vis;
    logic [23:0] distance;
    logic        found;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  grid_astar_path_search u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the block state; the map starts all free like the block
  bit [7:0]    map_prop [NCELL];
  bit          map_vis  [NCELL];
  int unsigned map_cost [NCELL];
  logic [1:0]  map_dx   [NCELL];
  logic [1:0]  map_dy   [NCELL];
  int unsigned heap_cell [HEAP_MAX];
  int unsigned heap_tot  [HEAP_MAX];
  int unsigned heap_seq  [HEAP_MAX];
  int          heap_n;
  int unsigned push_cnt;
  bit          heap_ovf;
  int unsigned wall_mult = 256;

  result_t expected_q[$];
  int      errors = 0;
  int      snd_pct = 21;
  int      rcv_pct = 50;

  const int NBX [8] = '{0, 0, -1, 1, -1, 1, 1, -1};
  const int NBY [8] = '{-1, 1, 0, 0, -1, 1, -1, 1};

  function automatic int unsigned octile(int x, int y, int ex, int ey);
    int dx, dy;
    dx = x > ex ? x - ex : ex - x;
    dy = y > ey ? y - ey : ey - y;
    return dx > dy ? dx * 256 + dy * 106 : dy * 256 + dx * 106;
  endfunction

  function automatic bit can_enter(logic [7:0] p, bit weapon);
    return weapon ? (p != PROP_SOLID) : (p == PROP_FREE);
  endfunction

  function automatic void heap_push(int unsigned c, int unsigned t);
    if (heap_n >= HEAP_MAX) begin
      heap_ovf = 1'b1;
      return;
    end
    heap_cell[heap_n] = c;
    heap_tot[heap_n]  = t;
    heap_seq[heap_n]  = push_cnt++;
    heap_n++;
  endfunction

  function automatic int unsigned heap_pop();
    int b;
    int unsigned c;
    b = 0;
    for (int i = 1; i < heap_n; i++)
      if (heap_tot[i] < heap_tot[b] ||
          (heap_tot[i] == heap_tot[b] && heap_seq[i] < heap_seq[b])) b = i;
    c = heap_cell[b];
    heap_n--;
    heap_cell[b] = heap_cell[heap_n];
    heap_tot[b]  = heap_tot[heap_n];
    heap_seq[b]  = heap_seq[heap_n];
    return c;
  endfunction

  function automatic void search_map(int sx, int sy, int ex, int ey, bit weapon,
                                     int unsigned depth);
    int unsigned st, cur, nc, stp, cst, tot;
    int cx, cy, nx, ny;
    for (int i = 0; i < NCELL; i++) map_vis[i] = 1'b0;
    heap_ovf = 1'b0;
    heap_n = 0;
    push_cnt = 0;
    st = sy * GW + sx;
    if (!can_enter(map_prop[st], weapon)) return;
    map_vis[st] = 1'b1;
    map_cost[st] = 0;
    map_dx[st] = 2'b00;
    map_dy[st] = 2'b00;
    heap_push(st, octile(sx, sy, ex, ey));
    while (heap_n > 0) begin
      cur = heap_pop();
      cx = cur % GW;
      cy = cur / GW;
      for (int i = 0; i < 8; i++) begin
        nx = cx + NBX[i];
        ny = cy + NBY[i];
        if (nx < 0 || ny < 0 || nx >= GW || ny >= GW) continue;
        nc = ny * GW + nx;
        if (!can_enter(map_prop[nc], weapon)) continue;
        stp = i < 4 ? 256 : 362;
        if (map_prop[nc] == PROP_WALL) stp = (stp * wall_mult + 128) >> 8;
        cst = map_cost[cur] + stp;
        if (cst > COST_SAT) cst = COST_SAT;
        if (!map_vis[nc] || cst < map_cost[nc]) begin
          map_vis[nc] = 1'b1;
          map_cost[nc] = cst;
          map_dx[nc] = NBX[i][1:0];
          map_dy[nc] = NBY[i][1:0];
          tot = cst + octile(nx, ny, ex, ey);
          if (tot < depth) heap_push(nc, tot);
        end
      end
    end
  endfunction

  function automatic result_t predict_word(logic [1:0] cmd, logic [IN_DATA_W-1:0] d);
    result_t r;
    int unsigned c, g;
    r = '0;
    c = d[11:6] * GW + d[5:0];
    case (cmd)
      CMD_WRITE: map_prop[c] = d[19:12];
      CMD_SEARCH: begin
        search_map(d[25:20], d[31:26], d[37:32], d[43:38], d[44], d[68:45]);
        g = d[43:38] * GW + d[37:32];
        if (map_vis[g]) begin
          r.found = 1'b1;
          r.distance = map_cost[g][23:0];
        end
      end
      CMD_READ: if (map_vis[c]) begin
        r.vis = 1'b1;
        r.cost = map_cost[c][23:0];
        r.dx = map_dx[c];
        r.dy = map_dy[c];
      end
      default: ;
    endcase
    r.ovf = heap_ovf;
    return r;
  endfunction

  // drive one word; valid stays high afterwards unless the next call idles
  task automatic send_word(logic [1:0] cmd, int cx, int cy, int val, int sx, int sy,
                           int ex, int ey, bit weapon, int unsigned depth);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[5:0] = 6'(cx); d[11:6] = 6'(cy); d[19:12] = 8'(val);
    d[25:20] = 6'(sx); d[31:26] = 6'(sy); d[37:32] = 6'(ex); d[43:38] = 6'(ey);
    d[44] = weapon; d[68:45] = 24'(depth);
    while ($urandom_range(0, 99) < snd_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= cmd;
    do @(posedge clk); while (!in_tready);
    expected_q = {expected_q, predict_word(cmd, d)};
  endtask

  task automatic write_cell(int x, int y, int v);
    send_word(CMD_WRITE, x, y, v, $urandom, $urandom, $urandom, $urandom, 1'($urandom),
              $urandom);
  endtask

  task automatic read_cell(int x, int y);
    send_word(CMD_READ, x, y, $urandom, $urandom, $urandom, $urandom, $urandom,
              1'($urandom), $urandom);
  endtask

  task automatic find_path(int sx, int sy, int ex, int ey, bit weapon, int unsigned depth);
    send_word(CMD_SEARCH, $urandom, $urandom, $urandom, sx, sy, ex, ey, weapon, depth);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_wall_mult(int unsigned m);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= CFG_W'(m);
    wall_mult = m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(0, 99) >= rcv_pct);

  always @(posedge clk) begin
    result_t got, exp;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[54:0];
      if (expected_q.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        errors++;
      end else begin
        exp = expected_q[0];
        expected_q.delete(0);
        if (got.found !== exp.found) begin
          $error("found exp %0d got %0d", exp.found, got.found); errors++;
        end
        if (got.distance !== exp.distance) begin
          $error("distance exp %0d got %0d", exp.distance, got.distance); errors++;
        end
        if (got.vis !== exp.vis) begin
          $error("visited exp %0d got %0d", exp.vis, got.vis); errors++;
        end
        if (got.cost !== exp.cost) begin
          $error("cell_cost exp %0d got %0d", exp.cost, got.cost); errors++;
        end
        if (got.dx !== exp.dx) begin
          $error("step_dx exp %b got %b", exp.dx, got.dx); errors++;
        end
        if (got.dy !== exp.dy) begin
          $error("step_dy exp %b got %b", exp.dy, got.dy); errors++;
        end
        if (got.ovf !== exp.ovf) begin
          $error("open_overflow exp %0d got %0d", exp.ovf, got.ovf); errors++;
        end
      end
    end
  end

  // 3x3 pocket in the corner fenced by solid cells keeps deep searches short
  task automatic test_pocket();
    for (int i = 0; i < 4; i++) write_cell(3, i, PROP_SOLID);
    for (int i = 0; i < 3; i++) write_cell(i, 3, PROP_SOLID);
    write_cell(2, 2, PROP_WALL);
    write_cell(1, 2, 8'h40);
    find_path(0, 0, 2, 2, 1'b0, 24'hFFFFFF);   // goal is a wall, not passable
    read_cell(1, 1);
    read_cell(2, 2);
    find_path(0, 0, 2, 2, 1'b1, 24'hFFFFFF);   // wall at reset multiplier
    read_cell(2, 2);
    read_cell(0, 0);
    read_cell(1, 2);
    find_path(3, 0, 0, 0, 1'b1, 24'hFFFFFF);   // start on solid
    read_cell(3, 0);
    find_path(1, 1, 63, 63, 1'b0, 24'd0);      // depth 0: only the start is expanded
    read_cell(1, 1);
    send_word(CMD_UNKNOWN, 63, 63, 255, 63, 63, 63, 63, 1'b1, 24'hFFFFFF);
    find_path(40, 40, 42, 41, 1'b0, octile(40, 40, 42, 41) + 512);
    read_cell(41, 41);
    read_cell(63, 63);
  endtask

  task automatic test_wall_mult_extremes();
    set_wall_mult(4095);
    find_path(0, 0, 2, 2, 1'b1, 24'hFFFFFF);
    read_cell(2, 2);
    set_wall_mult(256);
    find_path(2, 2, 0, 0, 1'b1, 24'hFFFFFF);
    read_cell(0, 1);
  endtask

  task automatic random_words(int n);
    int k, sx, sy, ex, ey, x, y, v;
    for (int j = 0; j < n; j++) begin
      k = $urandom_range(0, 99);
      if (k < 25) begin
        do begin
          x = $urandom_range(0, 63); y = $urandom_range(0, 63);
        end while (x <= 3 && y <= 3);
        v = $urandom_range(0, 99);
        v = v < 55 ? 0 : v < 70 ? 1 : v < 80 ? 255 : $urandom_range(0, 255);
        write_cell(x, y, v);
      end else if (k < 55) begin
        if ($urandom_range(0, 4) == 0) begin
          find_path($urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 63),
                    $urandom_range(0, 63), 1'($urandom), $urandom_range(0, 24'hFFFFFF));
        end else begin
          sx = $urandom_range(4, 59); sy = $urandom_range(4, 59);
          ex = sx + $urandom_range(0, 8) - 4; ey = sy + $urandom_range(0, 8) - 4;
          find_path(sx, sy, ex, ey, 1'($urandom),
                    $urandom_range(0, 3) == 0 ? $urandom_range(0, 600)
                                              : octile(sx, sy, ex, ey) + $urandom_range(0, 900));
        end
      end else if (k < 95) begin
        read_cell($urandom_range(0, 63), $urandom_range(0, 63));
      end else begin
        send_word(CMD_UNKNOWN, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, 1'($urandom), $urandom);
      end
    end
  endtask

  // reads near the last search hit visited cells far more often
  task automatic random_local(int n, int cx, int cy);
    for (int j = 0; j < n; j++)
      read_cell(cx + $urandom_range(0, 6) - 3, cy + $urandom_range(0, 6) - 3);
  endtask

  task automatic test_random();
    int sx, sy;
    snd_pct = 21; rcv_pct = 50;
    random_words(22);
    set_wall_mult($urandom_range(257, 4094));
    sx = $urandom_range(10, 50); sy = $urandom_range(10, 50);
    find_path(sx, sy, sx + 2, sy + 1, 1'b1, octile(sx, sy, sx + 2, sy + 1) + 800);
    random_local(6, sx, sy);
    drain();
    snd_pct = 50; rcv_pct = 21;
    random_words(22);
    set_wall_mult(4095);
    snd_pct = 0; rcv_pct = 0;
    random_words(22);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_pocket();
    test_wall_mult_extremes();
    test_random();
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
